[sv/stt_pkg.sv]
// Shared types, character codes and byte classification for the tokenizer.
package stt_pkg;

	// Result kinds
	typedef enum logic [3:0] {
		KIND_SEMI     = 4'd0,
		KIND_COLON    = 4'd1,
		KIND_LPAREN   = 4'd2,
		KIND_RPAREN   = 4'd3,
		KIND_LBRACK   = 4'd4,
		KIND_RBRACK   = 4'd5,
		KIND_EQUAL    = 4'd6,
		KIND_COMMA    = 4'd7,
		KIND_INT      = 4'd8,
		KIND_NAME     = 4'd9,
		KIND_NAMECHAR = 4'd10,
		KIND_ERROR    = 4'd11,
		KIND_END      = 4'd12
	} tok_kind_t;

	// Result fields other than the integer value
	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] name_char;
		logic [7:0] name_length;
		logic       done;
		logic       last;
	} tok_info_t;

	// Character codes
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_ident_char(input logic [7:0] b);
		return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z))
			|| (b == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b == CH_SEMI) || (b == CH_COLON) || (b == CH_LPAREN) || (b == CH_RPAREN)
			|| (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_EQUAL) || (b == CH_COMMA);
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] b);
		tok_kind_t k;
		unique case (b)
			CH_SEMI:   k = KIND_SEMI;
			CH_COLON:  k = KIND_COLON;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACK: k = KIND_LBRACK;
			CH_RBRACK: k = KIND_RBRACK;
			CH_EQUAL:  k = KIND_EQUAL;
			default:   k = KIND_COMMA;
		endcase
		return k;
	endfunction

	function automatic tok_info_t mk_info(input tok_kind_t k, input logic [7:0] ch,
			input logic [7:0] len);
		tok_info_t r;
		r.kind        = k;
		r.name_char   = ch;
		r.name_length = len;
		r.done        = 1'b0;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

[sv/stt_byte_if.sv]
// Input channel: one source text byte per request.
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source(output valid, output in_byte, output end_of_input, input ready);
	modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

[sv/stt_tok_if.sv]
// Output channel: one token result per request.
interface stt_tok_if #(
	parameter int INT_BITS = 31
);
	logic                valid;
	logic                ready;
	logic [3:0]          token_kind;
	logic [INT_BITS-1:0] int_value;
	logic [7:0]          name_char;
	logic [7:0]          name_length;
	logic                stream_done;
	logic                last;

	modport source(output valid, output token_kind, output int_value, output name_char,
		output name_length, output stream_done, output last, input ready);
	modport sink(input valid, input token_kind, input int_value, input name_char,
		input name_length, input stream_done, input last, output ready);
endinterface

[sv/stt_lexer.sv]
// Lexer state and per-byte result logic: up to two results per byte.
module stt_lexer import stt_pkg::*; #(
	parameter int MAX_RUN_LENGTH = 255,
	parameter int INT_BITS       = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          in_byte,
	input  logic                end_of_input,
	output logic [1:0]          res_cnt,
	output tok_info_t           res_info  [2],
	output logic [INT_BITS-1:0] res_value [2]
);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_NAME = 2'd2,
		MODE_ERR  = 2'd3
	} mode_t;

	localparam logic [7:0]          MAX_RUN = 8'(MAX_RUN_LENGTH);
	localparam logic [INT_BITS-1:0] MAXV    = {INT_BITS{1'b1}};

	mode_t               mode_q, mode_d;
	logic [INT_BITS-1:0] acc_q, acc_d;
	logic [7:0]          len_q, len_d;

	logic                digit, namech, space, punct, err, held;
	logic [1:0]          n;
	logic [INT_BITS+3:0] acc_ext, acc_mul;

	// Accumulate value*10 + digit with saturation
	always_comb begin
		acc_ext = {4'd0, acc_q};
		acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{INT_BITS{1'b0}}, in_byte[3:0]};
	end

	// Per-byte results and next state
	always_comb begin
		digit  = is_digit(in_byte);
		namech = is_ident_char(in_byte);
		space  = is_space(in_byte);
		punct  = is_punct(in_byte);
		mode_d = mode_q;
		acc_d  = acc_q;
		len_d  = len_q;
		err    = 1'b0;
		held   = 1'b0;
		n      = 2'd0;
		for (int i = 0; i < 2; i++) begin
			res_info[i]  = mk_info(KIND_END, 8'd0, 8'd0);
			res_value[i] = '0;
		end

		if (mode_q != MODE_ERR) begin
			// close a pending run on a byte of another class
			if (mode_q == MODE_INT && !digit) begin
				res_info[n[0]]  = mk_info(KIND_INT, 8'd0, 8'd0);
				res_value[n[0]] = acc_q;
				n      = n + 2'd1;
				mode_d = MODE_IDLE;
			end else if (mode_q == MODE_NAME && !namech) begin
				res_info[n[0]] = mk_info(KIND_NAME, 8'd0, len_q);
				n      = n + 2'd1;
				mode_d = MODE_IDLE;
			end

			// new byte
			if (punct) begin
				res_info[n[0]] = mk_info(punct_kind(in_byte), 8'd0, 8'd0);
				n = n + 2'd1;
			end else if (digit) begin
				if (mode_d == MODE_INT) begin
					if (len_q >= MAX_RUN) begin
						err = 1'b1;
					end else begin
						acc_d = (acc_mul[INT_BITS+3:INT_BITS] != 4'd0) ? MAXV
							: acc_mul[INT_BITS-1:0];
						len_d = len_q + 8'd1;
					end
				end else begin
					mode_d = MODE_INT;
					acc_d  = {{(INT_BITS-4){1'b0}}, in_byte[3:0]};
					len_d  = 8'd1;
				end
			end else if (namech) begin
				if (mode_d == MODE_NAME && len_q >= MAX_RUN) begin
					err = 1'b1;
				end else begin
					if (mode_d == MODE_NAME) begin
						len_d = len_q + 8'd1;
					end else begin
						mode_d = MODE_NAME;
						len_d  = 8'd1;
					end
					if (end_of_input) begin
						held = 1'b1;
					end else begin
						res_info[n[0]] = mk_info(KIND_NAMECHAR, in_byte, 8'd0);
						n = n + 2'd1;
					end
				end
			end else if (!space) begin
				err = 1'b1;
			end

			if (err) begin
				res_info[n[0]] = mk_info(KIND_ERROR, 8'd0, 8'd0);
				n      = n + 2'd1;
				mode_d = MODE_ERR;
				acc_d  = '0;
				len_d  = 8'd0;
			end
		end

		// final byte: flush the pending run, or report end
		if (end_of_input) begin
			if (mode_d == MODE_INT) begin
				res_info[n[0]]  = mk_info(KIND_INT, 8'd0, 8'd0);
				res_value[n[0]] = acc_d;
				n = n + 2'd1;
			end else if (mode_d == MODE_NAME) begin
				res_info[n[0]] = mk_info(KIND_NAME, held ? in_byte : 8'd0, len_d);
				n = n + 2'd1;
			end
			if (n == 2'd0) begin
				res_info[0] = mk_info(KIND_END, 8'd0, 8'd0);
				n = 2'd1;
			end
			res_info[n[1]].done = 1'b1;
			mode_d = MODE_IDLE;
			acc_d  = '0;
			len_d  = 8'd0;
		end

		if (n != 2'd0) begin
			res_info[n[1]].last = 1'b1;
		end
		res_cnt = en ? n : 2'd0;
	end

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			len_q  <= 8'd0;
		end else if (en) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			len_q  <= len_d;
		end
	end

endmodule

[sv/stt_result_fifo.sv]
// Result queue: takes up to two entries per cycle, gives one per cycle while rd_ready is high.
module stt_result_fifo #(
	parameter int WIDTH = 53,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 wr_cnt,
	input  logic [WIDTH-1:0]           wr_data [2],
	input  logic                       rd_ready,
	output logic                       rd_valid,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             pop;

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign count    = cnt_q;
	assign pop      = rd_valid && rd_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[wp_q] <= wr_data[0];
		end
		if (wr_cnt == 2'd2) begin
			mem_q[wp_q + PW'(1)] <= wr_data[1];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(wr_cnt);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + CW'(wr_cnt) - CW'(pop);
		end
	end

endmodule

[sv/source_text_tokenizer_unit.sv]
// Source text tokenizer top level: input register, lexer, result queue.
// An accepted byte is held in the input register, lexed combinationally, and its results
// are written to the queue, from which the first is then offered. Throughput: one byte per
// cycle; results leave at one per cycle while tokens.ready is high, from an 8-entry queue,
// and input stalls while it holds more than four entries (bytes that give two results can
// outpace the output). Reset (arst_n low) empties the queue and returns the lexer to idle.
module source_text_tokenizer_unit import stt_pkg::*; #(
	parameter int MAX_RUN_LENGTH = 255,
	parameter int INT_BITS       = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	stt_byte_if.sink   text,
	stt_tok_if.source  tokens
);

	localparam int FIFO_DEPTH = 8;
	localparam int INFO_W     = $bits(tok_info_t);
	localparam int RES_W      = INFO_W + INT_BITS;
	localparam int CW         = $clog2(FIFO_DEPTH + 1);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eoi_s1;
	logic                accept;
	logic [1:0]          res_cnt;
	tok_info_t           res_info  [2];
	logic [INT_BITS-1:0] res_value [2];
	logic [RES_W-1:0]    wr_data   [2];
	logic [RES_W-1:0]    rd_data;
	logic [CW-1:0]       count;
	tok_info_t           head_info;

	// Room for two requests in flight, two results each
	assign text.ready = (count <= CW'(FIFO_DEPTH - 4));
	assign accept     = text.valid && text.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text.in_byte;
			eoi_s1  <= text.end_of_input;
		end
	end

	stt_lexer #(
		.MAX_RUN_LENGTH(MAX_RUN_LENGTH),
		.INT_BITS      (INT_BITS)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1),
		.in_byte     (byte_s1),
		.end_of_input(eoi_s1),
		.res_cnt     (res_cnt),
		.res_info    (res_info),
		.res_value   (res_value)
	);

	// Pack results for the queue
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			wr_data[i] = {res_info[i], res_value[i]};
		end
	end

	stt_result_fifo #(
		.WIDTH(RES_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (res_cnt),
		.wr_data (wr_data),
		.rd_ready(tokens.ready),
		.rd_valid(tokens.valid),
		.rd_data (rd_data),
		.count   (count)
	);

	// Output fields
	assign head_info          = rd_data[RES_W-1:INT_BITS];
	assign tokens.token_kind  = head_info.kind;
	assign tokens.int_value   = rd_data[INT_BITS-1:0];
	assign tokens.name_char   = head_info.name_char;
	assign tokens.name_length = head_info.name_length;
	assign tokens.stream_done = head_info.done;
	assign tokens.last        = head_info.last;

endmodule
